// ===== hdl/lcs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_pkg
// shared types and codes of the link connection sequencer
// ----------------------------------------------------------------------------
package lcs_pkg;

    localparam int CNT_W       = 26;
    localparam int MAX_DEVICES = 8;

    localparam logic [CNT_W-1:0] RELOAD_RESET = CNT_W'(50000000);

    // commands
    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_INQ     = 3'd1;
    localparam logic [2:0] CMD_CANCEL  = 3'd2;
    localparam logic [2:0] CMD_CONNECT = 3'd3;
    localparam logic [2:0] CMD_CTRL    = 3'd4;
    localparam logic [2:0] CMD_INTR    = 3'd5;
    localparam logic [2:0] CMD_DRIVER  = 3'd6;

    // phases
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_INQ    = 3'd1;
    localparam logic [2:0] PH_CANCEL = 3'd2;
    localparam logic [2:0] PH_CONN   = 3'd3;
    localparam logic [2:0] PH_CTRL   = 3'd4;
    localparam logic [2:0] PH_INTR   = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;

    // events
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_TIMEOUT = 2'd1;
    localparam logic [1:0] EV_LOST    = 2'd2;

    typedef struct packed {
        logic       link_up;
        logic       ctrl_open;
        logic       intr_open;
        logic       inquiry_done;
        logic       found_valid;
        logic [2:0] found_index;
    } lcs_status_t;

    typedef struct packed {
        logic [2:0] command;
        logic [2:0] target_index;
        logic [2:0] phase;
        logic [1:0] event_res;
    } lcs_result_t;

endpackage
`default_nettype wire

// ===== hdl/link_connection_sequencer_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// link_connection_sequencer_unit
// phase machine that brings up a link to a wanted controller, one status
// word in, one command word out
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  status    in         status_valid / status_stall  lcs_status_t
//  result    out        result_valid / result_stall  lcs_result_t
//  cfg       in         cfg_write_en                 cfg_write_data (26 bit)
//
//  one status word per clock while neither stall is up; its result word goes
//  through the input register, then the result register
//  the phase/countdown update between the two registers sets the rate
//  result_stall holds the result register; the input register keeps taking
//  words until it too is full, then status_stall rises
//  rst_n clears phase, countdown, target, driver mark; reload goes to 50000000
// ----------------------------------------------------------------------------
module link_connection_sequencer_unit
    import lcs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             status_valid,
    output logic                  status_stall,
    input  wire lcs_status_t      status,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output lcs_result_t           result,
    input  wire logic             cfg_write_en,
    input  wire logic [CNT_W-1:0] cfg_write_data
);

    logic             s1_valid_reg;
    logic             s1_valid_next;
    lcs_status_t      s1_data_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    lcs_result_t      out_data_reg;
    lcs_result_t      out_data_next;

    logic [CNT_W-1:0] reload_reg;
    logic [2:0]       phase_reg;
    logic [2:0]       phase_next;
    logic [CNT_W-1:0] countdown_reg;
    logic [CNT_W-1:0] countdown_next;
    logic [2:0]       target_reg;
    logic [2:0]       target_next;
    logic             driver_reg;
    logic             driver_next;

    logic             advance;
    logic             accept_in;

    assign advance      = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign status_stall = s1_valid_reg && !advance;
    assign accept_in    = status_valid && !status_stall;

    assign s1_valid_next  = accept_in || (s1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && result_stall);

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // next state for the word in the input register
    always_comb
    begin
        logic             link;
        logic             ctrl;
        logic             intr;
        logic             found;
        logic [2:0]       ph;
        logic [CNT_W-1:0] cd;
        logic [CNT_W-1:0] cd_dec;
        logic             expired;
        logic [2:0]       cmd;
        logic [2:0]       tgt;
        logic [1:0]       ev;

        link  = s1_data_reg.link_up;
        ctrl  = s1_data_reg.ctrl_open;
        intr  = s1_data_reg.intr_open;
        found = s1_data_reg.found_valid &&
                (int'(s1_data_reg.found_index) < MAX_DEVICES);
        ph    = phase_reg;
        cd    = countdown_reg;
        cmd   = CMD_NONE;
        tgt   = 3'd0;
        ev    = EV_NONE;
        target_next = target_reg;
        driver_next = driver_reg;

        // link already up: skip ahead
        if (link && (ph <= PH_CONN))
        begin
            if (intr)
            begin
                if (!driver_reg)
                begin
                    driver_next = 1'b1;
                    cmd         = CMD_DRIVER;
                end
                ph = PH_DONE;
            end
            else if (!ctrl)
            begin
                cmd = CMD_CTRL;
                ph  = PH_CTRL;
                cd  = reload_reg;
            end
        end

        // saturating decrement
        cd_dec  = (cd == '0) ? cd : cd - CNT_W'(1);
        expired = (cd_dec == '0);

        unique case (ph)
            PH_INQ:
            begin
                cd = cd_dec;
                if (found)
                begin
                    target_next = s1_data_reg.found_index;
                    cmd         = CMD_CANCEL;
                    ph          = PH_CANCEL;
                    cd          = reload_reg;
                end
                else if (s1_data_reg.inquiry_done || expired)
                begin
                    cmd = CMD_INQ;
                    cd  = reload_reg;
                end
            end
            PH_CANCEL:
            begin
                cd = cd_dec;
                if (expired || s1_data_reg.inquiry_done)
                begin
                    cmd = CMD_CONNECT;
                    tgt = target_reg;
                    ph  = PH_CONN;
                    cd  = reload_reg;
                end
            end
            PH_CONN:
            begin
                cd = cd_dec;
                if (link)
                begin
                    cmd = CMD_CTRL;
                    ph  = PH_CTRL;
                    cd  = reload_reg;
                end
                else if (expired)
                begin
                    ev = EV_TIMEOUT;
                    ph = PH_IDLE;
                    cd = '0;
                end
            end
            PH_CTRL:
            begin
                cd = cd_dec;
                if (ctrl)
                begin
                    cmd = CMD_INTR;
                    ph  = PH_INTR;
                    cd  = reload_reg;
                end
                else if (expired)
                begin
                    ev = EV_TIMEOUT;
                    ph = PH_IDLE;
                    cd = '0;
                end
            end
            PH_INTR:
            begin
                cd = cd_dec;
                if (intr)
                begin
                    cmd         = CMD_DRIVER;
                    driver_next = 1'b1;
                    ph          = PH_DONE;
                end
                else if (expired)
                begin
                    ev = EV_TIMEOUT;
                    ph = PH_IDLE;
                    cd = '0;
                end
            end
            PH_DONE:
            begin
                if (!link)
                begin
                    ev = EV_LOST;
                    ph = PH_IDLE;
                    cd = '0;
                end
            end
            default:
            begin
                // idle, and the unused code behaves as idle
                ph = PH_IDLE;
                if (link)
                begin
                    if (intr)
                    begin
                        if (!driver_reg)
                        begin
                            driver_next = 1'b1;
                            cmd         = CMD_DRIVER;
                        end
                        ph = PH_DONE;
                    end
                    else
                    begin
                        cmd = CMD_CTRL;
                        ph  = PH_CTRL;
                        cd  = reload_reg;
                    end
                end
                else if (cd == '0)
                begin
                    cmd = CMD_INQ;
                    ph  = PH_INQ;
                    cd  = reload_reg;
                end
            end
        endcase

        phase_next     = ph;
        countdown_next = cd;
        out_data_next.command      = cmd;
        out_data_next.target_index = tgt;
        out_data_next.phase        = ph;
        out_data_next.event_res    = ev;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            reload_reg    <= RELOAD_RESET;
            phase_reg     <= PH_IDLE;
            countdown_reg <= '0;
            target_reg    <= 3'd0;
            driver_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                reload_reg <= cfg_write_data;
            end
            if (advance)
            begin
                phase_reg     <= phase_next;
                countdown_reg <= countdown_next;
                target_reg    <= target_next;
                driver_reg    <= driver_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            s1_data_reg <= status;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTHESIS
    // target is shown only with a connect command
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg.command != CMD_CONNECT))
            |-> (out_data_reg.target_index == 3'd0))
        else $error("target index set without connect");

    // any event drops the machine back to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg.event_res != EV_NONE))
            |-> (out_data_reg.phase == PH_IDLE))
        else $error("event reported outside idle");

    // the shown phase is the stored phase right after a word moves on
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(advance) |-> (out_data_reg.phase == phase_reg))
        else $error("result phase differs from stored phase");

    // create driver always leaves the driver mark set
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg.command == CMD_DRIVER)) |-> driver_reg)
        else $error("driver command without driver mark");
`endif

endmodule
`default_nettype wire
